@@ hdl/keypad_scan_debounce_assert.svh @@
// assertion macros for the keypad scanner
// both macros expect aclk and aresetn in scope
`ifndef KEYPAD_SCAN_DEBOUNCE_ASSERT_SVH
`define KEYPAD_SCAN_DEBOUNCE_ASSERT_SVH

`ifndef SYNTHESIS
`define KPSD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("keypad scanner check failed");
`define KPSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("keypad scanner check failed");
`else
`define KPSD_ASSERT_SAME(lbl, ante, cons)
`define KPSD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ hdl/kpsd_pkg.sv @@
package kpsd_pkg;

    localparam int COLS = 4;

    // register indexes of the configuration port
    localparam logic [3:0] REG_DEBOUNCE = 4'd0;
    localparam logic [3:0] REG_REPEAT   = 4'd1;
    localparam logic [3:0] REG_RELEASE  = 4'd2;
    localparam logic [3:0] REG_PAUSE    = 4'd3;

    typedef logic [1:0] row_idx_t;
    typedef logic [3:0] col_bits_t;
    typedef logic [7:0] key_code_t;

    // result of checking one row's columns
    typedef struct packed {
        logic      hit;
        key_code_t code;
    } pick_t;

    // ascii code of the key at (row, col)
    function automatic key_code_t key_map(input row_idx_t row, input logic [1:0] col);
        key_code_t k;
        k = 8'h00;
        unique case ({row, col})
            4'h0: k = "1";
            4'h1: k = "2";
            4'h2: k = "3";
            4'h3: k = "A";
            4'h4: k = "4";
            4'h5: k = "5";
            4'h6: k = "6";
            4'h7: k = "B";
            4'h8: k = "7";
            4'h9: k = "8";
            4'hA: k = "9";
            4'hB: k = "C";
            4'hC: k = "*";
            4'hD: k = "0";
            4'hE: k = "#";
            4'hF: k = "D";
            default: k = 8'h00;
        endcase
        return k;
    endfunction

endpackage

@@ hdl/kpsd_pick.sv @@
module kpsd_pick (
    input  kpsd_pkg::row_idx_t  row,
    input  kpsd_pkg::col_bits_t col_levels,
    input  kpsd_pkg::key_code_t last_code,
    input  logic                repeat_ok,
    output kpsd_pkg::pick_t     pick
);
    import kpsd_pkg::*;

    key_code_t cand [COLS];
    logic [COLS-1:0] elig;

    // a pressed key is eligible when new or when the repeat time has run out
    always_comb begin
        for (int c = 0; c < COLS; c++) begin
            cand[c] = key_map(row, c[1:0]);
            elig[c] = !col_levels[c] && ((cand[c] != last_code) || repeat_ok);
        end
    end

    // lowest eligible column wins
    always_comb begin
        pick.hit  = 1'b0;
        pick.code = 8'h00;
        priority if (elig[0]) begin
            pick.hit  = 1'b1;
            pick.code = cand[0];
        end else if (elig[1]) begin
            pick.hit  = 1'b1;
            pick.code = cand[1];
        end else if (elig[2]) begin
            pick.hit  = 1'b1;
            pick.code = cand[2];
        end else if (elig[3]) begin
            pick.hit  = 1'b1;
            pick.code = cand[3];
        end
    end

endmodule

@@ hdl/keypad_scan_debounce.sv @@
// result: registered; an accepted input transaction presents its result transaction in the next cycle
// throughput: one transaction per cycle; the output register is refilled in the
//   cycle it is drained, so only a stalled result holds off the input side
// reset: aresetn is synchronous, active low; timing registers return to
//   50 / 200 / 500 / 10 ticks, scanner goes idle, last key cleared, key released
module keypad_scan_debounce (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration write port
    input  logic                cfg_we,
    input  logic [3:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    // input channel: one transaction per millisecond tick
    input  logic                s_valid,
    output logic                s_ready,
    input  kpsd_pkg::col_bits_t s_col_levels,
    // result channel
    output logic                m_valid,
    input  logic                m_ready,
    output logic [3:0]          m_row_drive,
    output logic                m_key_valid,
    output kpsd_pkg::key_code_t m_key_code,
    output logic                m_key_held
);
    import kpsd_pkg::*;

    `include "keypad_scan_debounce_assert.svh"

    localparam logic [3:0] ROWS_IDLE = 4'hF;

    typedef enum logic {
        PH_IDLE,
        PH_SCAN
    } phase_t;

    // configuration registers
    logic [15:0] debounce_reg, repeat_reg, release_reg;
    logic [7:0]  pause_ms_reg;

    // scanner state
    phase_t      phase_reg, phase_next;
    row_idx_t    row_reg, row_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [15:0] start_reg, start_next;
    logic [7:0]  pause_cnt_reg, pause_cnt_next;
    key_code_t   last_reg, last_next;
    logic        released_reg, released_next;

    // result register
    logic        m_valid_reg;
    logic [3:0]  rows_reg, rows_next;
    logic        kvalid_reg;
    key_code_t   code_reg;
    logic        held_reg;

    logic        xfer;
    logic [15:0] elapsed_inc;
    logic [7:0]  pause_inc;
    pick_t       pick;
    logic        scan_hit;

    // result register frees up in the same cycle it is taken
    assign s_ready = !m_valid_reg || m_ready;
    assign xfer    = s_valid && s_ready;

    // column check for the row whose levels arrive on this tick
    kpsd_pick u_pick (
        .row        (row_reg),
        .col_levels (s_col_levels),
        .last_code  (last_reg),
        .repeat_ok  (start_reg > repeat_reg),
        .pick       (pick)
    );

    // a key counts only while a scan is running
    assign scan_hit = (phase_reg == PH_SCAN) && pick.hit;

    // saturating tick counters
    assign elapsed_inc = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;
    assign pause_inc   = (pause_cnt_reg == 8'hFF) ? pause_cnt_reg : pause_cnt_reg + 8'd1;

    // next state and result for one tick
    always_comb begin
        phase_next     = phase_reg;
        row_next       = row_reg;
        elapsed_next   = elapsed_inc;
        start_next     = start_reg;
        pause_cnt_next = pause_cnt_reg;
        last_next      = last_reg;
        released_next  = released_reg;
        rows_next      = ROWS_IDLE;
        unique case (phase_reg)
            PH_SCAN: begin
                if (pick.hit) begin
                    // key accepted: back to idle, restart the elapsed count
                    last_next      = pick.code;
                    elapsed_next   = 16'd0;
                    released_next  = 1'b0;
                    phase_next     = PH_IDLE;
                    pause_cnt_next = 8'd0;
                end else if (row_reg == 2'd3) begin
                    // full scan with nothing accepted; release test only here
                    if (start_reg > release_reg) begin
                        last_next     = 8'h00;
                        released_next = 1'b1;
                    end
                    phase_next     = PH_IDLE;
                    pause_cnt_next = 8'd0;
                end else begin
                    row_next  = row_reg + 2'd1;
                    rows_next = ROWS_IDLE & ~(4'b0001 << (row_reg + 2'd1));
                end
            end
            PH_IDLE: begin
                pause_cnt_next = pause_inc;
                // a zero pause setting behaves like one, since pause_inc is never zero
                if (pause_inc >= pause_ms_reg) begin
                    pause_cnt_next = 8'd0;
                    if (elapsed_inc >= debounce_reg) begin
                        // scan starts, row 0 driven low on this tick
                        start_next = elapsed_inc;
                        phase_next = PH_SCAN;
                        row_next   = 2'd0;
                        rows_next  = ROWS_IDLE & ~4'b0001;
                    end
                end
            end
            default: ;
        endcase
    end

    // configuration and scanner state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg  <= 16'd50;
            repeat_reg    <= 16'd200;
            release_reg   <= 16'd500;
            pause_ms_reg  <= 8'd10;
            phase_reg     <= PH_IDLE;
            row_reg       <= 2'd0;
            elapsed_reg   <= 16'd0;
            start_reg     <= 16'd0;
            pause_cnt_reg <= 8'd0;
            last_reg      <= 8'h00;
            released_reg  <= 1'b1;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_DEBOUNCE: debounce_reg <= cfg_data;
                    REG_REPEAT:   repeat_reg   <= cfg_data;
                    REG_RELEASE:  release_reg  <= cfg_data;
                    REG_PAUSE:    pause_ms_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (xfer) begin
                phase_reg     <= phase_next;
                row_reg       <= row_next;
                elapsed_reg   <= elapsed_next;
                start_reg     <= start_next;
                pause_cnt_reg <= pause_cnt_next;
                last_reg      <= last_next;
                released_reg  <= released_next;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (xfer) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (xfer) begin
            rows_reg   <= rows_next;
            kvalid_reg <= scan_hit;
            code_reg   <= (phase_reg == PH_SCAN) ? pick.code : 8'h00;
            held_reg   <= !released_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_row_drive = rows_reg;
    assign m_key_valid = kvalid_reg;
    assign m_key_code  = code_reg;
    assign m_key_held  = held_reg;

    // a reported key always comes with rows released and the key marked held
    `KPSD_ASSERT_SAME(a_key_rows_idle, m_valid && m_key_valid, m_row_drive == ROWS_IDLE && m_key_held)
    // no key reported means code zero
    `KPSD_ASSERT_SAME(a_code_zero, m_valid && !m_key_valid, m_key_code == 8'h00)
    // an accepted key ends the scan and restarts the elapsed count
    `KPSD_ASSERT_NEXT(a_hit_ends_scan, xfer && scan_hit, phase_reg == PH_IDLE && elapsed_reg == 16'd0)
    // every accepted transaction produces a result
    `KPSD_ASSERT_NEXT(a_result_follows, xfer, m_valid)
    // a released key leaves no last key behind
    `KPSD_ASSERT_SAME(a_release_clears, released_reg, last_reg == 8'h00)

endmodule

@@ sim/tb_keypad_scan_debounce.sv @@
`timescale 1ns / 100ps

module tb_keypad_scan_debounce;
    import kpsd_pkg::*;

    // timing values the block comes out of reset with
    localparam logic [15:0] RST_DEBOUNCE = 16'd50;
    localparam logic [15:0] RST_REPEAT   = 16'd200;
    localparam logic [15:0] RST_RELEASE  = 16'd500;
    localparam logic [7:0]  RST_PAUSE    = 8'd10;

    // key legend, row 0 in the low bytes, column 0 in the low byte of each row
    localparam logic [127:0] KEY_CHARS = {"D#0*", "C987", "B654", "A321"};

    // hand-picked column levels for the directed part: all pressed, none,
    // single columns low, same column held for repeats
    localparam logic [95:0] DIRECTED_COLS = 96'hF0FEDB7FFEEE00FFFF7BDEF0;
    localparam int DIRECTED_COUNT = 24;

    localparam int RANDOM_ROUNDS = 6;
    localparam int STALL_LIMIT = 1000;

    typedef enum logic [1:0] {
        SCAN_IDLE   = 2'd0,
        SCAN_ACTIVE = 2'd1
    } scan_phase_e;

    // one result transaction
    typedef struct packed {
        logic [3:0] row_drive;
        logic       key_valid;
        key_code_t  key_code;
        logic       key_held;
    } tick_result_t;

    // scoreboard: keeps its own copy of the scanner state and timing registers,
    // predicts the result of every accepted tick and checks results in order
    class key_tick_board;
        logic [15:0]  debounce_ms;
        logic [15:0]  repeat_ms;
        logic [15:0]  release_ms;
        logic [7:0]   pause_ms;
        logic [15:0]  elapsed;
        logic [15:0]  start_elapsed;
        logic [7:0]   pause_count;
        scan_phase_e  phase;
        logic [1:0]   scan_row;
        key_code_t    last_key;
        logic         released;
        tick_result_t expected_ticks[$];
        int           checked;
        int           mismatches;
        int           scan_ticks;
        int           keys_seen;
        int           release_timeouts;

        function new();
            debounce_ms      = RST_DEBOUNCE;
            repeat_ms        = RST_REPEAT;
            release_ms       = RST_RELEASE;
            pause_ms         = RST_PAUSE;
            elapsed          = '0;
            start_elapsed    = '0;
            pause_count      = '0;
            phase            = SCAN_IDLE;
            scan_row         = '0;
            last_key         = '0;
            released         = 1'b1;
            checked          = 0;
            mismatches       = 0;
            scan_ticks       = 0;
            keys_seen        = 0;
            release_timeouts = 0;
        endfunction

        function void write_reg(logic [3:0] idx, logic [15:0] data);
            case (idx)
                REG_DEBOUNCE: debounce_ms = data;
                REG_REPEAT:   repeat_ms = data;
                REG_RELEASE:  release_ms = data;
                REG_PAUSE:    pause_ms = data[7:0];
                default: ;
            endcase
        endfunction

        // advance the scanner by one tick and queue the result it produces
        function void note_tick(col_bits_t cols);
            tick_result_t res;
            logic [1:0]   row;
            logic         hit;
            key_code_t    code;
            key_code_t    k;
            int           c;

            res.row_drive = 4'hF;
            hit = 1'b0;
            code = '0;
            if (elapsed != 16'hFFFF) elapsed++;

            if (phase == SCAN_ACTIVE) begin
                scan_ticks++;
                row = scan_row;
                // lowest pressed column wins, if it is new or its repeat time is up
                for (c = 0; c < COLS; c++) begin
                    if (!hit && !cols[c]) begin
                        k = KEY_CHARS[(row * 4 + c) * 8 +: 8];
                        if (k != last_key || start_elapsed > repeat_ms) begin
                            hit = 1'b1;
                            code = k;
                        end
                    end
                end
                if (hit) begin
                    keys_seen++;
                    last_key = code;
                    elapsed = '0;
                    released = 1'b0;
                    phase = SCAN_IDLE;
                    pause_count = '0;
                end else if (row == 2'd3) begin
                    // empty full scan, forget the key once the release time is up
                    if (start_elapsed > release_ms) begin
                        release_timeouts++;
                        last_key = '0;
                        released = 1'b1;
                    end
                    phase = SCAN_IDLE;
                    pause_count = '0;
                end else begin
                    scan_row = row + 2'd1;
                    res.row_drive = 4'hF & ~(4'b0001 << scan_row);
                end
            end else begin
                phase = SCAN_IDLE;
                if (pause_count != 8'hFF) pause_count++;
                // a zero pause behaves like one, every idle tick is an attempt
                if (pause_count >= pause_ms) begin
                    pause_count = '0;
                    if (elapsed >= debounce_ms) begin
                        start_elapsed = elapsed;
                        phase = SCAN_ACTIVE;
                        scan_row = '0;
                        res.row_drive = 4'hE;
                    end
                end
            end

            res.key_valid = hit;
            res.key_code = code;
            res.key_held = !released;
            expected_ticks.push_back(res);
        endfunction

        function void report_mismatch(string what);
            mismatches++;
            if (mismatches <= 10) $display("tick %0d: %s", checked, what);
        endfunction

        function void check_tick(tick_result_t got);
            tick_result_t exp;
            if (expected_ticks.size() == 0) begin
                report_mismatch($sformatf(
                    "result with no tick pending: rows %h valid %b code %h held %b",
                    got.row_drive, got.key_valid, got.key_code, got.key_held));
            end else begin
                exp = expected_ticks.pop_front();
                if (got.row_drive !== exp.row_drive || got.key_valid !== exp.key_valid ||
                    got.key_code !== exp.key_code || got.key_held !== exp.key_held) begin
                    report_mismatch($sformatf(
                        "exp rows %h valid %b code %h held %b, got rows %h valid %b code %h held %b",
                        exp.row_drive, exp.key_valid, exp.key_code, exp.key_held,
                        got.row_drive, got.key_valid, got.key_code, got.key_held));
                end
            end
            checked++;
        endfunction

        function int pending();
            return expected_ticks.size();
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       cfg_we;
    logic [3:0] cfg_index;
    logic [15:0] cfg_data;
    logic       s_valid;
    logic       s_ready;
    col_bits_t  s_col_levels;
    logic       m_valid;
    logic       m_ready;
    logic [3:0] m_row_drive;
    logic       m_key_valid;
    key_code_t  m_key_code;
    logic       m_key_held;

    key_tick_board sb = new();

    // keys held down on the simulated keypad, bit 4*row+col
    logic [15:0] pad_keys = '0;
    // when set, neither side inserts idle cycles
    logic steady = 1'b0;
    int settings_used = 0;
    int stall_cycles = 0;

    keypad_scan_debounce u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_col_levels (s_col_levels),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_row_drive  (m_row_drive),
        .m_key_valid  (m_key_valid),
        .m_key_code   (m_key_code),
        .m_key_held   (m_key_held)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // one register write, taken at the next rising edge
    task automatic cfg_write(input logic [3:0] idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        sb.write_reg(idx, data);
    endtask

    // load all four timing registers plus one write to an unused index
    task automatic set_timing(input logic [15:0] deb, input logic [15:0] rep,
                              input logic [15:0] rel, input logic [15:0] pau,
                              input logic [3:0] stray_idx);
        cfg_write(REG_DEBOUNCE, deb);
        cfg_write(REG_REPEAT, rep);
        cfg_write(REG_RELEASE, rel);
        cfg_write(REG_PAUSE, pau);
        cfg_write(stray_idx, 16'($urandom_range(0, 16'hFFFF)));
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // hold off the sender until every queued result is back, then let the
    // result register drain before touching the registers
    task automatic settle();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // one input transaction; valid stays up if the next one follows at once
    task automatic send_tick(input col_bits_t cols);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_col_levels <= cols;
        do @(posedge aclk); while (!s_ready);
        sb.note_tick(cols);
    endtask

    // random ticks from a simulated keypad: keys pressed and released now and
    // then, column levels following the row driven on the previous tick, with
    // some noise mixed in; stops after scan_goal scan ticks or tick_cap ticks
    task automatic run_ticks(input int scan_goal, input int tick_cap);
        int        first_scan;
        int        n;
        int        pick;
        col_bits_t cols;
        first_scan = sb.scan_ticks;
        for (n = 0; n < tick_cap && sb.scan_ticks - first_scan < scan_goal; n++) begin
            if ($urandom_range(0, 29) == 0) begin
                pick = $urandom_range(0, 9);
                if (pick < 4) pad_keys = '0;
                else if (pick < 9) pad_keys = 16'h0001 << $urandom_range(0, 15);
                else pad_keys = 16'($urandom_range(0, 16'hFFFF));
            end
            if (sb.phase == SCAN_ACTIVE && $urandom_range(0, 6) != 0)
                cols = ~pad_keys[{sb.scan_row, 2'b00} +: 4];
            else
                cols = col_bits_t'($urandom_range(0, 15));
            send_tick(cols);
        end
        s_valid <= 1'b0;
    endtask

    // result side: random ready gaps, every transaction goes to the scoreboard
    initial begin
        int           gap;
        tick_result_t got;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            gap = steady ? 0 : $urandom_range(0, 4);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got.row_drive = m_row_drive;
            got.key_valid = m_key_valid;
            got.key_code  = m_key_code;
            got.key_held  = m_key_held;
            sb.check_tick(got);
        end
    end

    // watchdog: too long without any transaction on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results pending",
                STALL_LIMIT, sb.pending());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int i;
        int round;
        aresetn      <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        s_valid      <= 1'b0;
        s_col_levels <= 4'hF;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset timing: slow debounce and pause, a few scans only
        pad_keys = 16'h0001 << $urandom_range(0, 15);
        run_ticks(12, 100);
        settle();

        // directed: every timer at zero, pause of zero, raw column patterns
        set_timing(16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'hF);
        for (i = 0; i < DIRECTED_COUNT; i++)
            send_tick(DIRECTED_COLS[i * 4 +: 4]);
        s_valid <= 1'b0;
        settle();

        // random short timings, every third round without idle cycles
        for (round = 0; round < RANDOM_ROUNDS; round++) begin
            steady = (round % 3 == 2);
            set_timing(16'($urandom_range(0, 15)), 16'($urandom_range(0, 40)),
                16'($urandom_range(0, 60)), 16'($urandom_range(0, 6)),
                4'($urandom_range(4, 15)));
            run_ticks(20, 35);
            settle();
        end
        steady = 1'b0;

        // widest repeat and release, longest pause; upper pause bits are dropped
        set_timing(16'h0000, 16'hFFFF, 16'hFFFF, 16'hABFF, 4'h4);
        run_ticks(12, 40);
        settle();

        // longest debounce: no scan can start in the ticks that follow
        set_timing(16'hFFFF, 16'hFFFF, 16'hFFFE, 16'h0001, 4'($urandom_range(4, 15)));
        run_ticks(4, 30);
        settle();

        $display("ran %0d ticks, %0d inside a scan, %0d keys reported, %0d release timeouts",
            sb.checked, sb.scan_ticks, sb.keys_seen, sb.release_timeouts);
        $display("%0d timing settings from all zeros to the widest values, %0d mismatches",
            settings_used, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
